>>> design/rmcs_pkg.sv
// ----------------------------------------------------------------------------
// rmcs_pkg
// Shared types and constants of the notch resonator model / chi-square block.
// ----------------------------------------------------------------------------
package rmcs_pkg;

    localparam int unsigned CORDIC_STEPS_DEF = 18;
    localparam int unsigned QUEUE_DEPTH      = 2;
    localparam int unsigned CFG_IDX_W        = 3;
    localparam int unsigned CFG_DATA_W       = 36;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOADED_QUALITY       = 3'd0,
        CFG_COUPLING_MAGNITUDE   = 3'd1,
        CFG_COUPLING_ANGLE       = 3'd2,
        CFG_RESONANCE_FREQUENCY  = 3'd3,
        CFG_BASELINE_AMPLITUDE   = 3'd4,
        CFG_BASELINE_PHASE       = 3'd5,
        CFG_CABLE_DELAY          = 3'd6
    } rmcs_cfg_idx_t;

    localparam logic [23:0] RST_LOADED_QUALITY      = 24'd6000;
    localparam logic [19:0] RST_COUPLING_MAGNITUDE  = 20'd65536;
    localparam logic [15:0] RST_COUPLING_ANGLE      = 16'd54613;
    localparam logic [35:0] RST_RESONANCE_FREQUENCY = 36'd1342177280;
    localparam logic [23:0] RST_BASELINE_AMPLITUDE  = 24'd4194304;
    localparam logic [15:0] RST_BASELINE_PHASE      = 16'd29204;
    localparam logic [31:0] RST_CABLE_DELAY         = 32'd464728883;

    typedef struct packed {
        logic [23:0]        loaded_quality;
        logic signed [19:0] coupling_magnitude;
        logic [15:0]        coupling_angle;
        logic [35:0]        resonance_frequency;
        logic [23:0]        baseline_amplitude;
        logic [15:0]        baseline_phase;
        logic signed [31:0] cable_delay;
    } rmcs_cfg_t;

    typedef struct packed {
        logic [35:0]        frequency;
        logic signed [23:0] measured_real;
        logic signed [23:0] measured_imag;
        logic               last;
    } rmcs_in_t;

    typedef struct packed {
        logic signed [23:0] model_real;
        logic signed [23:0] model_imag;
        logic [63:0]        chi_square;
        logic               sweep_done;
    } rmcs_out_t;

    // request handed from front to back
    typedef struct packed {
        logic [60:0]        num;
        logic               neg;
        logic [31:0]        phase;
        logic signed [23:0] measured_real;
        logic signed [23:0] measured_imag;
        logic               last;
    } rmcs_job_t;

    // zero resonance frequency acts as one LSB
    function automatic logic [35:0] f0_eff(input logic [35:0] f0);
        f0_eff = (f0 == 36'd0) ? 36'd1 : f0;
    endfunction

endpackage

>>> design/rmcs_front.sv
// ----------------------------------------------------------------------------
// rmcs_front
// Accepts samples, forms the detuning numerator and the delay phase angle.
// ----------------------------------------------------------------------------
module rmcs_front import rmcs_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  rmcs_cfg_t cfg,
    input  logic      s_valid,
    output logic      s_ready,
    input  rmcs_in_t  s_data,
    output logic      job_valid,
    input  logic      job_ready,
    output rmcs_job_t job
);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_LO   = 4'b0010,
        F_HI   = 4'b0100,
        F_PUSH = 4'b1000
    } fstate_t;

    fstate_t            state_reg, state_next;
    rmcs_in_t           item_reg, item_next;
    logic [35:0]        absd_reg, absd_next;
    logic               neg_reg, neg_next;
    logic [41:0]        num_lo_reg, num_lo_next;
    logic signed [50:0] ph_lo_reg, ph_lo_next;
    rmcs_job_t          job_reg, job_next;

    logic [36:0]        diff;
    logic [41:0]        num_hi;
    logic [59:0]        num_sum;
    logic signed [50:0] ph_hi;
    logic [51:0]        prod;

    assign s_ready   = (state_reg == F_IDLE);
    assign job_valid = (state_reg == F_PUSH);
    assign job       = job_reg;

    assign diff    = {1'b0, s_data.frequency} - {1'b0, f0_eff(cfg.resonance_frequency)};
    assign num_hi  = cfg.loaded_quality * absd_reg[35:18];
    assign num_sum = {num_hi, 18'd0} + 60'(num_lo_reg);
    assign ph_hi   = cfg.cable_delay * $signed({1'b0, item_reg.frequency[35:18]});
    assign prod    = 52'(ph_lo_reg) + {ph_hi[33:0], 18'd0};

    always_comb begin
        state_next  = state_reg;
        item_next   = item_reg;
        absd_next   = absd_reg;
        neg_next    = neg_reg;
        num_lo_next = num_lo_reg;
        ph_lo_next  = ph_lo_reg;
        job_next    = job_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    neg_next   = diff[36];
                    absd_next  = diff[36] ? 36'(-diff) : diff[35:0];
                    state_next = F_LO;
                end
            end
            F_LO: begin
                num_lo_next = cfg.loaded_quality * absd_reg[17:0];
                ph_lo_next  = cfg.cable_delay * $signed({1'b0, item_reg.frequency[17:0]});
                state_next  = F_HI;
            end
            F_HI: begin
                job_next.num           = {num_sum, 1'b0};
                job_next.neg           = neg_reg;
                job_next.phase         = {cfg.baseline_phase, 16'd0} - prod[51:20];
                job_next.measured_real = item_reg.measured_real;
                job_next.measured_imag = item_reg.measured_imag;
                job_next.last          = item_reg.last;
                state_next             = F_PUSH;
            end
            F_PUSH: begin
                if (job_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        item_reg   <= item_next;
        absd_reg   <= absd_next;
        neg_reg    <= neg_next;
        num_lo_reg <= num_lo_next;
        ph_lo_reg  <= ph_lo_next;
        job_reg    <= job_next;
    end

endmodule

>>> design/rmcs_queue.sv
// ----------------------------------------------------------------------------
// rmcs_queue
// Short request queue between front and back.
// ----------------------------------------------------------------------------
module rmcs_queue import rmcs_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  rmcs_job_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output rmcs_job_t out_data
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    rmcs_job_t        mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

>>> design/rmcs_cordic.sv
// ----------------------------------------------------------------------------
// rmcs_cordic
// Iterative rotation-mode CORDIC on 32-bit binary angles, Q30 outputs.
// ----------------------------------------------------------------------------
module rmcs_cordic import rmcs_pkg::*; #(
    parameter int unsigned STEPS = CORDIC_STEPS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [31:0]        angle,
    output logic               busy,
    output logic signed [32:0] cos_q30,
    output logic signed [32:0] sin_q30
);

    localparam int unsigned CNT_W = $clog2(STEPS + 1);
    localparam logic signed [32:0] GAIN_Q30 = 33'sd652032874;
    localparam logic [29:0] ATAN_TURNS [32] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
        30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
        30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
        30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
    };

    logic signed [32:0] x_reg, x_next, y_reg, y_next;
    logic signed [33:0] z_reg, z_next;
    logic               flip_reg, flip_next;
    logic               busy_reg, busy_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    logic signed [33:0] z_ext;
    logic [4:0]         k;
    logic signed [32:0] dx, dy;
    logic signed [33:0] at;

    assign busy    = busy_reg;
    assign cos_q30 = flip_reg ? -x_reg : x_reg;
    assign sin_q30 = flip_reg ? -y_reg : y_reg;

    assign z_ext = 34'($signed(angle));
    assign k     = 5'(cnt_reg);
    assign dx    = y_reg >>> k;
    assign dy    = x_reg >>> k;
    assign at    = $signed({4'd0, ATAN_TURNS[k]});

    always_comb begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        flip_next = flip_reg;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start) begin
            x_next    = GAIN_Q30;
            y_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
            flip_next = 1'b0;
            z_next    = z_ext;
            if (z_ext > 34'sd1073741824) begin
                z_next    = z_ext - 34'sd2147483648;
                flip_next = 1'b1;
            end else if (z_ext < -34'sd1073741824) begin
                z_next    = z_ext + 34'sd2147483648;
                flip_next = 1'b1;
            end
        end else if (busy_reg) begin
            if (!z_reg[33]) begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - at;
            end else begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + at;
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(STEPS - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
    end

endmodule

>>> design/rmcs_div.sv
// ----------------------------------------------------------------------------
// rmcs_div
// Restoring divider, one quotient bit per cycle, up to 31 bits.
// ----------------------------------------------------------------------------
module rmcs_div import rmcs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] den,
    input  logic [63:0] rem_init,
    input  logic [31:0] bits,
    input  logic [4:0]  n_iter,
    output logic        busy,
    output logic [31:0] quot
);

    logic [63:0] den_reg, den_next;
    logic [63:0] rem_reg, rem_next;
    logic [31:0] bits_reg, bits_next;
    logic [31:0] quot_reg, quot_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;

    logic [64:0] r2;
    logic        ge;

    assign busy = busy_reg;
    assign quot = quot_reg;
    assign r2   = {rem_reg, bits_reg[31]};
    assign ge   = (r2 >= {1'b0, den_reg});

    always_comb begin
        den_next  = den_reg;
        rem_next  = rem_reg;
        bits_next = bits_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            den_next  = den;
            rem_next  = rem_init;
            bits_next = bits;
            quot_next = '0;
            cnt_next  = n_iter;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = ge ? 64'(r2 - {1'b0, den_reg}) : r2[63:0];
            quot_next = {quot_reg[30:0], ge};
            bits_next = {bits_reg[30:0], 1'b0};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == 5'd1) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        bits_reg <= bits_next;
        quot_reg <= quot_next;
    end

endmodule

>>> design/rmcs_back.sv
// ----------------------------------------------------------------------------
// rmcs_back
// Sequencer: detuning divide, CORDIC pair, complex quotient, model point and
// saturating residual sum, with a registered result stage.
// ----------------------------------------------------------------------------
module rmcs_back import rmcs_pkg::*; #(
    parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  rmcs_cfg_t cfg,
    input  logic      q_valid,
    output logic      q_ready,
    input  rmcs_job_t q_data,
    output logic      m_valid,
    input  logic      m_ready,
    output rmcs_out_t m_data
);

    typedef enum logic [10:0] {
        B_IDLE = 11'b00000000001,
        B_RUN  = 11'b00000000010,
        B_PROD = 11'b00000000100,
        B_NUM  = 11'b00000001000,
        B_DIV  = 11'b00000010000,
        B_W    = 11'b00000100000,
        B_M1   = 11'b00001000000,
        B_M2   = 11'b00010000000,
        B_M3   = 11'b00100000000,
        B_SQ   = 11'b01000000000,
        B_OUT  = 11'b10000000000
    } bstate_t;

    function automatic logic signed [23:0] sat24(input logic signed [36:0] v);
        if (v > 37'sd8388607) begin
            sat24 = 24'sd8388607;
        end else if (v < -37'sd8388608) begin
            sat24 = -24'sd8388608;
        end else begin
            sat24 = 24'(v);
        end
    endfunction

    bstate_t            state_reg, state_next;
    rmcs_job_t          job_reg, job_next;
    logic               sat_reg, sat_next;
    logic [30:0]        bmag_reg, bmag_next;
    logic signed [31:0] b_reg, b_next;
    logic signed [50:0] sb_reg, sb_next, cb_reg, cb_next;
    logic signed [27:0] pr_reg, pr_next, pi_reg, pi_next;
    logic               nr_neg_reg, nr_neg_next, ni_neg_reg, ni_neg_next;
    logic signed [24:0] rr_reg, rr_next, ri_reg, ri_next;
    logic signed [29:0] inn_r_reg, inn_r_next, inn_i_reg, inn_i_next;
    logic signed [57:0] pa_reg, pa_next, pb_reg, pb_next;
    logic signed [57:0] pc_reg, pc_next, pd_reg, pd_next;
    logic signed [23:0] mr_reg, mr_next, mi_reg, mi_next;
    logic signed [49:0] sqr_reg, sqr_next, sqi_reg, sqi_next;
    logic [63:0]        residual_sum_reg, residual_sum_next;
    logic               m_valid_reg, m_valid_next;
    rmcs_out_t          m_data_reg, m_data_next;

    // shared datapath wires
    logic               cth_busy, cph_busy, bdiv_busy, rdiv_busy, idiv_busy;
    logic signed [32:0] cth, sth, cph, sph;
    logic [31:0]        bquot, rquot, iquot;
    logic               bdiv_start, cordic_start, cdiv_start;
    logic [35:0]        f0e;
    logic [45:0]        num_top;
    logic signed [18:0] c16, s16;
    logic signed [24:0] a_s;
    logic signed [57:0] ar_prod, ai_prod;
    logic [61:0]        bb;
    logic [63:0]        den;
    logic signed [51:0] nr, ni;
    logic [51:0]        nr_mag, ni_mag;
    logic signed [44:0] wr_prod, wi_prod;
    logic signed [58:0] sum_r, sum_i;
    logic signed [24:0] dr, di;
    logic [50:0]        sq;
    logic [64:0]        acc;
    logic [63:0]        chi;
    logic               out_load;

    assign f0e     = f0_eff(cfg.resonance_frequency);
    assign num_top = q_data.num[60:15];
    assign c16     = 19'(cth >>> 14);
    assign s16     = 19'(sth >>> 14);
    assign a_s     = $signed({1'b0, cfg.baseline_amplitude});
    assign ar_prod = a_s * cph;
    assign ai_prod = a_s * sph;
    assign bb      = bmag_reg * bmag_reg;
    assign den     = 64'(bb) + 64'h1_0000_0000;
    assign nr      = ($signed(52'(c16)) <<< 16) + 52'(sb_reg);
    assign ni      = ($signed(52'(s16)) <<< 16) - 52'(cb_reg);
    assign nr_mag  = nr[51] ? 52'(-nr) : nr;
    assign ni_mag  = ni[51] ? 52'(-ni) : ni;
    assign wr_prod = cfg.coupling_magnitude * rr_reg;
    assign wi_prod = cfg.coupling_magnitude * ri_reg;
    assign sum_r   = 59'(pa_reg) - 59'(pb_reg);
    assign sum_i   = 59'(pc_reg) + 59'(pd_reg);
    assign dr      = 25'(mr_reg) - 25'(job_reg.measured_real);
    assign di      = 25'(mi_reg) - 25'(job_reg.measured_imag);
    assign sq      = 51'(unsigned'(sqr_reg)) + 51'(unsigned'(sqi_reg));
    assign acc     = {1'b0, residual_sum_reg} + 65'(sq);
    assign chi     = acc[64] ? '1 : acc[63:0];

    assign q_ready      = (state_reg == B_IDLE);
    assign bdiv_start   = (state_reg == B_IDLE) && q_valid;
    assign cordic_start = bdiv_start;
    assign cdiv_start   = (state_reg == B_NUM);
    assign out_load     = (state_reg == B_OUT) && (!m_valid_reg || m_ready);
    assign m_valid      = m_valid_reg;
    assign m_data       = m_data_reg;

    rmcs_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_theta (
        .aclk(aclk), .aresetn(aresetn), .start(cordic_start),
        .angle({cfg.coupling_angle, 16'd0}), .busy(cth_busy),
        .cos_q30(cth), .sin_q30(sth)
    );

    rmcs_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_phase (
        .aclk(aclk), .aresetn(aresetn), .start(cordic_start),
        .angle(q_data.phase), .busy(cph_busy),
        .cos_q30(cph), .sin_q30(sph)
    );

    rmcs_div u_div_detune (
        .aclk(aclk), .aresetn(aresetn), .start(bdiv_start),
        .den(64'(f0e)), .rem_init(64'(num_top)),
        .bits({q_data.num[14:0], 17'd0}), .n_iter(5'd31),
        .busy(bdiv_busy), .quot(bquot)
    );

    rmcs_div u_div_real (
        .aclk(aclk), .aresetn(aresetn), .start(cdiv_start),
        .den(den), .rem_init(64'(nr_mag[51:2])),
        .bits({nr_mag[1:0], 30'd0}), .n_iter(5'd24),
        .busy(rdiv_busy), .quot(rquot)
    );

    rmcs_div u_div_imag (
        .aclk(aclk), .aresetn(aresetn), .start(cdiv_start),
        .den(den), .rem_init(64'(ni_mag[51:2])),
        .bits({ni_mag[1:0], 30'd0}), .n_iter(5'd24),
        .busy(idiv_busy), .quot(iquot)
    );

    always_comb begin
        state_next        = state_reg;
        job_next          = job_reg;
        sat_next          = sat_reg;
        bmag_next         = bmag_reg;
        b_next            = b_reg;
        sb_next           = sb_reg;
        cb_next           = cb_reg;
        pr_next           = pr_reg;
        pi_next           = pi_reg;
        nr_neg_next       = nr_neg_reg;
        ni_neg_next       = ni_neg_reg;
        rr_next           = rr_reg;
        ri_next           = ri_reg;
        inn_r_next        = inn_r_reg;
        inn_i_next        = inn_i_reg;
        pa_next           = pa_reg;
        pb_next           = pb_reg;
        pc_next           = pc_reg;
        pd_next           = pd_reg;
        mr_next           = mr_reg;
        mi_next           = mi_reg;
        sqr_next          = sqr_reg;
        sqi_next          = sqi_reg;
        residual_sum_next = residual_sum_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_data_next       = m_data_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    job_next   = q_data;
                    // quotient of 2^15 or more saturates
                    sat_next   = (num_top >= 46'(f0e));
                    state_next = B_RUN;
                end
            end
            B_RUN: begin
                if (!bdiv_busy && !cth_busy && !cph_busy) begin
                    bmag_next  = sat_reg ? 31'h7FFFFFFF : bquot[30:0];
                    b_next     = job_reg.neg ? -$signed({1'b0, (sat_reg ? 31'h7FFFFFFF : bquot[30:0])})
                                             : $signed({1'b0, (sat_reg ? 31'h7FFFFFFF : bquot[30:0])});
                    state_next = B_PROD;
                end
            end
            B_PROD: begin
                sb_next    = s16 * b_reg;
                cb_next    = c16 * b_reg;
                pr_next    = 28'(ar_prod >>> 30);
                pi_next    = 28'(ai_prod >>> 30);
                state_next = B_NUM;
            end
            B_NUM: begin
                nr_neg_next = nr[51];
                ni_neg_next = ni[51];
                state_next  = B_DIV;
            end
            B_DIV: begin
                if (!rdiv_busy && !idiv_busy) begin
                    rr_next    = nr_neg_reg ? -$signed({1'b0, rquot[23:0]})
                                            : $signed({1'b0, rquot[23:0]});
                    ri_next    = ni_neg_reg ? -$signed({1'b0, iquot[23:0]})
                                            : $signed({1'b0, iquot[23:0]});
                    state_next = B_W;
                end
            end
            B_W: begin
                inn_r_next = 30'sd4194304 - 30'(wr_prod >>> 16);
                inn_i_next = -30'(wi_prod >>> 16);
                state_next = B_M1;
            end
            B_M1: begin
                pa_next    = pr_reg * inn_r_reg;
                pb_next    = pi_reg * inn_i_reg;
                state_next = B_M2;
            end
            B_M2: begin
                pc_next    = pr_reg * inn_i_reg;
                pd_next    = pi_reg * inn_r_reg;
                state_next = B_M3;
            end
            B_M3: begin
                mr_next    = sat24(37'(sum_r >>> 22));
                mi_next    = sat24(37'(sum_i >>> 22));
                state_next = B_SQ;
            end
            B_SQ: begin
                sqr_next   = dr * dr;
                sqi_next   = di * di;
                state_next = B_OUT;
            end
            B_OUT: begin
                if (out_load) begin
                    m_valid_next           = 1'b1;
                    m_data_next.model_real = mr_reg;
                    m_data_next.model_imag = mi_reg;
                    m_data_next.chi_square = chi;
                    m_data_next.sweep_done = job_reg.last;
                    residual_sum_next      = job_reg.last ? '0 : chi;
                    state_next             = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= B_IDLE;
            residual_sum_reg <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            residual_sum_reg <= residual_sum_next;
            m_valid_reg      <= m_valid_next;
        end
        job_reg    <= job_next;
        sat_reg    <= sat_next;
        bmag_reg   <= bmag_next;
        b_reg      <= b_next;
        sb_reg     <= sb_next;
        cb_reg     <= cb_next;
        pr_reg     <= pr_next;
        pi_reg     <= pi_next;
        nr_neg_reg <= nr_neg_next;
        ni_neg_reg <= ni_neg_next;
        rr_reg     <= rr_next;
        ri_reg     <= ri_next;
        inn_r_reg  <= inn_r_next;
        inn_i_reg  <= inn_i_next;
        pa_reg     <= pa_next;
        pb_reg     <= pb_next;
        pc_reg     <= pc_next;
        pd_reg     <= pd_next;
        mr_reg     <= mr_next;
        mi_reg     <= mi_next;
        sqr_reg    <= sqr_next;
        sqi_reg    <= sqi_next;
        m_data_reg <= m_data_next;
    end

    a_sum_clears_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && job_reg.last) |=> (residual_sum_reg == '0))
        else $error("residual sum not cleared after sweep end");

    a_load_shows_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid_reg)
        else $error("result loaded but not presented");

    a_quot_divs_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        rdiv_busy == idiv_busy)
        else $error("quotient dividers out of step");

endmodule

>>> design/resonator_model_chi_square.sv
// A request passes the front end, the queue and the back-end states B_RUN through B_OUT
// to the result register. The back end takes a new request only in B_IDLE, after its
// 31-step detuning divide and 24-step complex-quotient divide for the last one.
// The front end takes the next request while the back end works on the current one.
// Reset (aresetn low, synchronous) restores register defaults, clears the residual
// sum, empties the queue and drops any pending result.
// ----------------------------------------------------------------------------
// resonator_model_chi_square
// Notch resonator model evaluation with a running saturating chi-square sum.
// ----------------------------------------------------------------------------
module resonator_model_chi_square import rmcs_pkg::*; #(
    parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  rmcs_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output rmcs_out_t             m_data
);

    rmcs_cfg_t cfg_reg, cfg_next;
    rmcs_job_t fq_data, qb_data;
    logic      fq_valid, fq_ready, qb_valid, qb_ready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (rmcs_cfg_idx_t'(cfg_idx))
                CFG_LOADED_QUALITY:      cfg_next.loaded_quality      = cfg_data[23:0];
                CFG_COUPLING_MAGNITUDE:  cfg_next.coupling_magnitude  = cfg_data[19:0];
                CFG_COUPLING_ANGLE:      cfg_next.coupling_angle      = cfg_data[15:0];
                CFG_RESONANCE_FREQUENCY: cfg_next.resonance_frequency = cfg_data[35:0];
                CFG_BASELINE_AMPLITUDE:  cfg_next.baseline_amplitude  = cfg_data[23:0];
                CFG_BASELINE_PHASE:      cfg_next.baseline_phase      = cfg_data[15:0];
                CFG_CABLE_DELAY:         cfg_next.cable_delay         = cfg_data[31:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.loaded_quality      <= RST_LOADED_QUALITY;
            cfg_reg.coupling_magnitude  <= RST_COUPLING_MAGNITUDE;
            cfg_reg.coupling_angle      <= RST_COUPLING_ANGLE;
            cfg_reg.resonance_frequency <= RST_RESONANCE_FREQUENCY;
            cfg_reg.baseline_amplitude  <= RST_BASELINE_AMPLITUDE;
            cfg_reg.baseline_phase      <= RST_BASELINE_PHASE;
            cfg_reg.cable_delay         <= RST_CABLE_DELAY;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    rmcs_front u_front (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_data)
    );

    rmcs_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(fq_valid), .in_ready(fq_ready), .in_data(fq_data),
        .out_valid(qb_valid), .out_ready(qb_ready), .out_data(qb_data)
    );

    rmcs_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .q_valid(qb_valid), .q_ready(qb_ready), .q_data(qb_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

endmodule
